FILE: design/mrmf_pkg.sv
// ----------------------------------------------------------------------------
// mrmf_pkg: shared types and constants
// Sizes, queue command format and configuration bundle of the diamond
// dilation filter.
// ----------------------------------------------------------------------------
package mrmf_pkg;

	localparam int MAX_ROWS   = 256;
	localparam int MAX_COLS   = 256;
	localparam int PIXEL_BITS = 10;
	localparam int ROW_W      = 8;
	localparam int COL_W      = 8;
	localparam int ADDR_W     = ROW_W + COL_W;
	localparam int FRAME_SIZE = MAX_ROWS * MAX_COLS;
	localparam int CNT_W      = 9;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_RUN  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_ROWS   = 2'd1;
	localparam logic [1:0] REG_COLS   = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_RUN,
		CMD_RDIN,
		CMD_RDOUT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic [ADDR_W-1:0]       addr;
		logic [PIXEL_BITS-1:0]   pix;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] radius;
		logic [CNT_W-1:0] rows;
		logic [CNT_W-1:0] cols;
	} cfg_t;

endpackage

FILE: design/mrmf_ram.sv
// ----------------------------------------------------------------------------
// mrmf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mrmf_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/mrmf_front.sv
// ----------------------------------------------------------------------------
// mrmf_front: input classifier and command queue
// Accepts items, drops ignored ones, queues commands for the back end.
// ----------------------------------------------------------------------------
module mrmf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrmf_pkg::cfg_t       cfg,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,  // row, col, pixel_in
	input  logic [1:0]           s_tuser,  // operation
	output logic                 cmd_valid,
	output mrmf_pkg::cmd_t       cmd,
	input  logic                 cmd_pop
);
	import mrmf_pkg::*;

	localparam int QD = 4;

	cmd_t            q_q [QD];
	logic [2:0]      wp_q, rp_q;
	logic            full, keep, in_img, push;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] col;
	cmd_t            nc;

	assign row    = s_tdata[ROW_W-1:0];
	assign col    = s_tdata[ROW_W+COL_W-1:ROW_W];
	assign in_img = ({1'b0, row} < cfg.rows) && ({1'b0, col} < cfg.cols);
	assign full   = (wp_q[1:0] == rp_q[1:0]) && (wp_q[2] != rp_q[2]);
	assign s_tready  = !full;
	assign cmd_valid = (wp_q != rp_q);
	assign cmd       = q_q[rp_q[1:0]];
	assign push      = s_tvalid && !full && keep;

	always_comb begin
		nc.addr = {row, col};
		nc.pix  = s_tdata[ADDR_W+PIXEL_BITS-1:ADDR_W];
		nc.kind = CMD_RUN;
		keep    = 1'b0;
		case (s_tuser)
			OP_LOAD: begin
				nc.kind = CMD_LOAD;
				keep    = in_img;
			end
			OP_RUN: begin
				nc.kind = CMD_RUN;
				keep    = 1'b1;
			end
			OP_READ: begin
				nc.kind = in_img ? CMD_RDIN : CMD_RDOUT;
				keep    = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q[1:0]] <= nc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 3'd1;
			if (cmd_pop) rp_q <= rp_q + 3'd1;
		end
	end

endmodule

FILE: design/mrmf_back.sv
// ----------------------------------------------------------------------------
// mrmf_back: frame memories and pass sequencer
// Executes loads, reads and dilation passes over two ping-pong frames.
// ----------------------------------------------------------------------------
module mrmf_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mrmf_pkg::cfg_t                  cfg,
	input  logic                            cmd_valid,
	input  mrmf_pkg::cmd_t                  cmd,
	output logic                            cmd_pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,  // pixel_out
	output logic                            m_tuser   // valid_res
);
	import mrmf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_PIX,
		ST_PASS_END
	} state_t;

	state_t                st_q;
	logic [2:0]            step_q;
	logic [CNT_W-1:0]      pass_q;
	logic [ROW_W-1:0]      r_q;
	logic [COL_W-1:0]      c_q;
	logic                  chg_q, odd_q, out_valid_q, out_ok_q;
	logic [PIXEL_BITS-1:0] ctr_q, acc_q, out_pix_q;

	logic [ADDR_W-1:0]     raddr, ctr_addr, nb_addr, even_waddr;
	logic [PIXEL_BITS-1:0] even_rd, odd_rd, src_rd, vmax, even_wdata;
	logic                  src_even, even_we, odd_we, last_c, last_r, out_free;

	assign src_even = pass_q[0];
	assign src_rd   = src_even ? even_rd : odd_rd;
	assign ctr_addr = {r_q, c_q};
	assign last_c   = !(({1'b0, c_q} + 9'd1) < cfg.cols);
	assign last_r   = !(({1'b0, r_q} + 9'd1) < cfg.rows);
	assign out_free = !out_valid_q;

	always_comb begin
		nb_addr = ctr_addr;
		case (step_q)
			3'd1: if (r_q != '0) nb_addr = {r_q - 8'd1, c_q};
			3'd2: if (c_q != '0) nb_addr = {r_q, c_q - 8'd1};
			3'd3: if (!last_r) nb_addr = {r_q + 8'd1, c_q};
			3'd4: if (!last_c) nb_addr = {r_q, c_q + 8'd1};
			default: nb_addr = ctr_addr;
		endcase
	end

	assign raddr = (st_q == ST_PIX) ? nb_addr : cmd.addr;
	assign vmax  = (src_rd > acc_q) ? src_rd : acc_q;

	always_comb begin
		cmd_pop = 1'b0;
		if (st_q == ST_IDLE && cmd_valid) begin
			case (cmd.kind)
				CMD_RDIN, CMD_RDOUT: cmd_pop = out_free;
				default:             cmd_pop = 1'b1;
			endcase
		end
	end

	assign even_we    = (cmd_pop && cmd.kind == CMD_LOAD) ||
	                    (st_q == ST_PIX && step_q == 3'd5 && !src_even);
	assign odd_we     = (st_q == ST_PIX && step_q == 3'd5 && src_even);
	assign even_waddr = (st_q == ST_PIX) ? ctr_addr : cmd.addr;
	assign even_wdata = (st_q == ST_PIX) ? vmax : cmd.pix;

	mrmf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(FRAME_SIZE)) u_even (
		.clk(clk), .we(even_we), .waddr(even_waddr), .wdata(even_wdata),
		.raddr(raddr), .rdata(even_rd)
	);

	mrmf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(FRAME_SIZE)) u_odd (
		.clk(clk), .we(odd_we), .waddr(ctr_addr), .wdata(vmax),
		.raddr(raddr), .rdata(odd_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			step_q      <= '0;
			pass_q      <= '0;
			r_q         <= '0;
			c_q         <= '0;
			chg_q       <= 1'b0;
			odd_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_ok_q    <= 1'b0;
			out_pix_q   <= '0;
			ctr_q       <= '0;
			acc_q       <= '0;
		end else begin
			if (out_valid_q && m_tready) out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.kind)
							CMD_RUN: begin
								if (cfg.radius == '0 || cfg.rows == '0 ||
								    cfg.cols == '0) begin
									odd_q <= cfg.radius[0];
								end else begin
									pass_q <= 9'd1;
									r_q    <= '0;
									c_q    <= '0;
									step_q <= '0;
									chg_q  <= 1'b0;
									st_q   <= ST_PIX;
								end
							end
							CMD_RDIN: st_q <= ST_RD_WAIT;
							CMD_RDOUT: begin
								out_valid_q <= 1'b1;
								out_pix_q   <= '0;
								out_ok_q    <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_RD_WAIT: begin
					out_valid_q <= 1'b1;
					out_pix_q   <= odd_q ? odd_rd : even_rd;
					out_ok_q    <= 1'b1;
					st_q        <= ST_IDLE;
				end
				ST_PIX: begin
					if (step_q == 3'd1) begin
						ctr_q <= src_rd;
						acc_q <= src_rd;
					end else if (step_q != 3'd0) begin
						acc_q <= vmax;
					end
					if (step_q == 3'd5) begin
						step_q <= '0;
						if (vmax != ctr_q) chg_q <= 1'b1;
						if (last_c) begin
							c_q <= '0;
							if (last_r) st_q <= ST_PASS_END;
							else r_q <= r_q + 8'd1;
						end else begin
							c_q <= c_q + 8'd1;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_PASS_END: begin
					if (!chg_q || pass_q == cfg.radius) begin
						odd_q <= cfg.radius[0];
						st_q  <= ST_IDLE;
					end else begin
						pass_q <= pass_q + 9'd1;
						chg_q  <= 1'b0;
						r_q    <= '0;
						c_q    <= '0;
						st_q   <= ST_PIX;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16 - PIXEL_BITS){1'b0}}, out_pix_q};
	assign m_tuser  = out_ok_q;

`ifndef SYNTHESIS
	a_wait_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RD_WAIT) |-> !out_valid_q)
		else $error("read issued while result register busy");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PIX) |-> (step_q <= 3'd5))
		else $error("pixel step out of range");
	a_pass_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PIX) |-> (pass_q != '0 && pass_q <= cfg.radius))
		else $error("pass count out of range");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !cmd_pop)
		else $error("command popped while busy");
`endif

endmodule

FILE: design/manhattan_radius_max_filter.sv
// ----------------------------------------------------------------------------
// manhattan_radius_max_filter: diamond-kernel grayscale dilation
// Load pixels, run radius dilation passes, read result pixels.
// ----------------------------------------------------------------------------
// A load item is written to the even frame as the back end pops it; a read
// item waits for a free result register before it is popped. A compute item
// scans every pixel once per pass, for up to radius passes, and stops early
// once a pass changes no pixel; the single read port of the source frame,
// five reads per pixel, sets its pace. A four-entry command queue lets items
// be taken while a pass runs. No clearing pass after reset.
module manhattan_radius_max_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // row[7:0], col[15:8], pixel_in[25:16]
	input  logic [1:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // pixel_out[9:0]
	output logic        m_tuser   // valid_res
);
	import mrmf_pkg::*;

	logic [CNT_W-1:0] radius_q, rows_q, cols_q;
	cfg_t             cfg;
	logic             cmd_valid, cmd_pop;
	cmd_t             cmd;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 9'd1;
			rows_q   <= 9'd256;
			cols_q   <= 9'd256;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_RADIUS: radius_q <= pwdata[CNT_W-1:0];
				REG_ROWS:   rows_q   <= pwdata[CNT_W-1:0];
				REG_COLS:   cols_q   <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RADIUS: prdata = {23'd0, radius_q};
			REG_ROWS:   prdata = {23'd0, rows_q};
			REG_COLS:   prdata = {23'd0, cols_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.radius = radius_q;
	assign cfg.rows   = (rows_q > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_q;
	assign cfg.cols   = (cols_q > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cols_q;

	mrmf_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	mrmf_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule
